/* hw/rtl/mecanum_wheel_speed_packetizer_top_assert.svh */
// Assertion macros used by the packetizer wheel queue.
// Both expect signals named clk and rst in the scope of use.
`ifndef MECANUM_WHEEL_SPEED_PACKETIZER_TOP_ASSERT_SVH
`define MECANUM_WHEEL_SPEED_PACKETIZER_TOP_ASSERT_SVH

// Same-cycle implication
`define MWSP_ASSERT_SAME(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("mwsp assertion failed");

// Next-cycle implication
`define MWSP_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("mwsp assertion failed");

`endif

/* hw/rtl/mwsp_pkg.sv */
package mwsp_pkg;

  localparam int MOTOR_COUNT         = 4;
  localparam int FRAME_LEN           = 10;
  localparam int QUEUE_DEPTH_DEFAULT = 4;

  localparam logic [8:0] WHEEL_RPM_CEIL = 9'd330;
  localparam logic [7:0] CRC_POLY       = 8'h8C;

  // Register reset values
  localparam logic [8:0]  RST_SPEED_CAP      = 9'd60;
  localparam logic [9:0]  RST_STOP_THRESHOLD = 10'd20;
  localparam logic [15:0] RST_ARM_GAIN       = 16'd49807;
  localparam logic [15:0] RST_RPM_GAIN       = 16'd7823;
  localparam logic [3:0]  RST_INVERT_MASK    = 4'd5;
  localparam logic [7:0]  RST_MODE_BYTE      = 8'h64;
  localparam logic [7:0]  RST_ACCEL_BYTE     = 8'h05;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_SPEED_CAP      = 3'd0,
    REG_STOP_THRESHOLD = 3'd1,
    REG_ARM_GAIN       = 3'd2,
    REG_RPM_GAIN       = 3'd3,
    REG_INVERT_MASK    = 3'd4,
    REG_MODE_BYTE      = 3'd5,
    REG_ACCEL_BYTE     = 3'd6
  } reg_index_t;

  typedef struct packed {
    logic [8:0]  speed_cap;
    logic [9:0]  stop_threshold;
    logic [15:0] arm_gain;
    logic [15:0] rpm_gain;
    logic [3:0]  invert_mask;
    logic [7:0]  mode_byte;
    logic [7:0]  accel_byte;
  } cfg_t;

  typedef logic [$clog2(MOTOR_COUNT)-1:0] wheel_t;

  // One wheel result handed from front to back
  typedef struct packed {
    wheel_t      wheel;
    logic [15:0] rpm;
  } wheel_cmd_t;

  // Byte positions within a motor frame
  localparam int BYTE_IDX_W = $clog2(FRAME_LEN);
  typedef logic [BYTE_IDX_W-1:0] byte_idx_t;

  localparam byte_idx_t BYTE_ID     = byte_idx_t'(0);
  localparam byte_idx_t BYTE_MODE   = byte_idx_t'(1);
  localparam byte_idx_t BYTE_RPM_HI = byte_idx_t'(2);
  localparam byte_idx_t BYTE_RPM_LO = byte_idx_t'(3);
  localparam byte_idx_t BYTE_ACCEL  = byte_idx_t'(6);
  localparam byte_idx_t BYTE_CRC    = byte_idx_t'(FRAME_LEN - 1);

  // Reflected CRC-8, one byte
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] data);
    logic [7:0] c;
    c = crc_in ^ data;
    for (int b = 0; b < 8; b++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

/* hw/rtl/mwsp_queue.sv */
`include "mecanum_wheel_speed_packetizer_top_assert.svh"

module mwsp_queue
  import mwsp_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  wheel_cmd_t push_data,
  output logic       full,
  input  logic       pop,
  output wheel_cmd_t head,
  output logic       empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  wheel_cmd_t     mem [DEPTH];
  logic [AW-1:0]  wr_ptr;
  logic [AW-1:0]  rd_ptr;
  logic [CW-1:0]  count;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  `MWSP_ASSERT_SAME(a_no_push_full, push, count != CW'(DEPTH))
  `MWSP_ASSERT_SAME(a_no_pop_empty, pop, count != '0)
  `MWSP_ASSERT_NEXT(a_count_up, push && !pop, count == $past(count) + 1'b1)

endmodule

/* hw/rtl/mwsp_front.sv */
module mwsp_front
  import mwsp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic signed [15:0] vel_x,
  input  logic signed [15:0] vel_y,
  input  logic signed [15:0] yaw_rate,
  output logic              push,
  output wheel_cmd_t        push_data,
  input  logic              q_full
);

  // Magnitude of a 16-bit two's complement value
  function automatic logic [16:0] mag17(input logic [15:0] v);
    return v[15] ? (17'd0 - {1'b1, v}) : {1'b0, v};
  endfunction

  // Stage 0: command, brake flag, yaw product
  logic               s0_valid;
  logic signed [15:0] s0_vx;
  logic signed [15:0] s0_vy;
  logic               s0_brake;
  logic signed [32:0] s0_wprod;

  // Stage 1: wheel sequencer
  logic               s1_valid;
  logic signed [15:0] s1_vx;
  logic signed [15:0] s1_vy;
  logic signed [16:0] s1_w;
  logic               s1_brake;
  wheel_t             s1_wheel;

  // Stage 2: scaled product
  logic               s2_valid;
  logic signed [34:0] s2_prod;
  logic               s2_brake;
  wheel_t             s2_wheel;

  logic               s1_last, s1_adv, s1_load, s2_adv, s2_free, s0_adv;
  logic               brake_in;
  logic signed [32:0] wprod_in;
  logic [9:0]         thr;

  // Handshake through the stages
  assign s1_last  = (s1_wheel == wheel_t'(MOTOR_COUNT - 1));
  assign s2_adv   = s2_valid && !q_full;
  assign s2_free  = !s2_valid || s2_adv;
  assign s1_adv   = s1_valid && s2_free;
  assign s1_load  = !s1_valid || (s1_adv && s1_last);
  assign s0_adv   = s0_valid && s1_load;
  assign in_ready = !s0_valid || s0_adv;

  // Brake test and yaw term on entry
  assign thr      = cfg.stop_threshold;
  assign brake_in = (mag17(vel_x) < {7'd0, thr}) && (mag17(vel_y) < {7'd0, thr}) &&
                    (mag17(yaw_rate) < {7'd0, thr});
  assign wprod_in = yaw_rate * $signed({1'b0, cfg.arm_gain});

  // Per-wheel rim speed: FL=x+y-w, FR=x-y+w, RL=x-y-w, RR=x+y+w
  logic               vy_sub, w_add;
  logic signed [17:0] vx_e, vy_e, w_e, sum;

  assign vy_sub = s1_wheel[0] ^ s1_wheel[1];
  assign w_add  = s1_wheel[0];
  assign vx_e   = {{2{s1_vx[15]}}, s1_vx};
  assign vy_e   = {{2{s1_vy[15]}}, s1_vy};
  assign w_e    = {s1_w[16], s1_w};
  assign sum    = vx_e + (vy_sub ? -vy_e : vy_e) + (w_add ? w_e : -w_e);

  // Truncate toward zero, saturate, invert, brake
  logic signed [18:0] r_floor, r_trunc, lim_e, r_sat, r_out;
  logic               r_round;
  logic [8:0]         lim;

  assign lim     = (cfg.speed_cap > WHEEL_RPM_CEIL) ? WHEEL_RPM_CEIL : cfg.speed_cap;
  assign lim_e   = {10'd0, lim};
  assign r_floor = s2_prod[34:16];
  assign r_round = s2_prod[34] && (s2_prod[15:0] != 16'd0);
  assign r_trunc = r_floor + {18'd0, r_round};

  always_comb begin
    if (r_trunc > lim_e) begin
      r_sat = lim_e;
    end else if (r_trunc < -lim_e) begin
      r_sat = -lim_e;
    end else begin
      r_sat = r_trunc;
    end
    if (s2_brake) begin
      r_out = '0;
    end else if (cfg.invert_mask[s2_wheel]) begin
      r_out = -r_sat;
    end else begin
      r_out = r_sat;
    end
  end

  assign push           = s2_adv;
  assign push_data.wheel = s2_wheel;
  assign push_data.rpm   = r_out[15:0];

  // Stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        s0_valid <= in_valid;
      end
      if (s1_load) begin
        s1_valid <= s0_valid;
      end
      if (s2_free) begin
        s2_valid <= s1_valid;
      end
    end
  end

  // Stage payloads
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s0_vx    <= vel_x;
      s0_vy    <= vel_y;
      s0_brake <= brake_in;
      s0_wprod <= wprod_in;
    end
    if (s1_load && s0_valid) begin
      s1_vx    <= s0_vx;
      s1_vy    <= s0_vy;
      s1_w     <= s0_wprod[32:16];
      s1_brake <= s0_brake;
      s1_wheel <= '0;
    end else if (s1_adv) begin
      s1_wheel <= s1_wheel + 1'b1;
    end
    if (s1_adv) begin
      s2_prod  <= sum * $signed({1'b0, cfg.rpm_gain});
      s2_brake <= s1_brake;
      s2_wheel <= s1_wheel;
    end
  end

endmodule

/* hw/rtl/mwsp_back.sv */
module mwsp_back
  import mwsp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       q_empty,
  input  wheel_cmd_t q_head,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic [2:0] motor_id,
  output logic       out_last
);

  logic       active;
  byte_idx_t  idx;
  wheel_cmd_t cur;
  logic [7:0] crc;

  logic       ld, emit;
  logic [7:0] sel;
  logic [7:0] head_id;

  assign ld      = !out_valid || out_ready;
  assign emit    = ld && (active || !q_empty);
  assign q_pop   = ld && !active && !q_empty;
  assign head_id = {6'd0, q_head.wheel} + 8'd1;

  // Frame byte for the current position
  always_comb begin
    case (idx)
      BYTE_ID:     sel = {6'd0, cur.wheel} + 8'd1;
      BYTE_MODE:   sel = cfg.mode_byte;
      BYTE_RPM_HI: sel = cur.rpm[15:8];
      BYTE_RPM_LO: sel = cur.rpm[7:0];
      BYTE_ACCEL:  sel = cfg.accel_byte;
      BYTE_CRC:    sel = crc;
      default:     sel = 8'd0;
    endcase
  end

  // Frame sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      out_valid <= 1'b0;
    end else if (ld) begin
      out_valid <= emit;
      if (active) begin
        active <= (idx != BYTE_CRC);
      end else if (!q_empty) begin
        active <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      if (active) begin
        out_byte <= sel;
        motor_id <= {1'b0, cur.wheel} + 3'd1;
        out_last <= (idx == BYTE_CRC) && (cur.wheel == wheel_t'(MOTOR_COUNT - 1));
        crc      <= crc8_byte(crc, sel);
        idx      <= idx + 1'b1;
      end else begin
        // First byte of a frame goes out as the entry is popped
        out_byte <= head_id;
        motor_id <= {1'b0, q_head.wheel} + 3'd1;
        out_last <= 1'b0;
        crc      <= crc8_byte(8'd0, head_id);
        idx      <= BYTE_MODE;
        cur      <= q_head;
      end
    end
  end

endmodule

/* hw/rtl/mecanum_wheel_speed_packetizer_top.sv */
// Channel    Dir  Handshake              Payload
// s_*        in   s_tvalid / s_tready    velocity command (vel_x, vel_y, yaw_rate)
// m_*        out  m_tvalid / m_tready    frame byte, motor id, tlast on final CRC
// cfg_*      in   cfg_we                 register index and value
//
// Each command produces 40 bytes, one per cycle while m_tready is high; the
// one-byte output register of the frame sequencer sets that rate.
// A command passes front stages 0, 1 and 2, the wheel queue and the output register.
// Reset is synchronous: it empties the pipeline and the wheel queue and loads
// the register defaults. m_tready low holds the output; the front keeps taking
// commands until the QUEUE_DEPTH-entry wheel queue fills.
module mecanum_wheel_speed_packetizer_top
  import mwsp_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // vel_x[15:0], vel_y[31:16], yaw_rate[47:32]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // out_byte[7:0], motor_id[10:8], zero[15:11]
  output logic        m_tlast,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t       cfg;
  logic       push, q_full, q_pop, q_empty;
  wheel_cmd_t push_data, q_head;
  logic [7:0] out_byte;
  logic [2:0] motor_id;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.speed_cap      <= RST_SPEED_CAP;
      cfg.stop_threshold <= RST_STOP_THRESHOLD;
      cfg.arm_gain       <= RST_ARM_GAIN;
      cfg.rpm_gain       <= RST_RPM_GAIN;
      cfg.invert_mask    <= RST_INVERT_MASK;
      cfg.mode_byte      <= RST_MODE_BYTE;
      cfg.accel_byte     <= RST_ACCEL_BYTE;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_SPEED_CAP:      cfg.speed_cap      <= cfg_data[8:0];
        REG_STOP_THRESHOLD: cfg.stop_threshold <= cfg_data[9:0];
        REG_ARM_GAIN:       cfg.arm_gain       <= cfg_data;
        REG_RPM_GAIN:       cfg.rpm_gain       <= cfg_data;
        REG_INVERT_MASK:    cfg.invert_mask    <= cfg_data[3:0];
        REG_MODE_BYTE:      cfg.mode_byte      <= cfg_data[7:0];
        REG_ACCEL_BYTE:     cfg.accel_byte     <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  mwsp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .vel_x     (s_tdata[15:0]),
    .vel_y     (s_tdata[31:16]),
    .yaw_rate  (s_tdata[47:32]),
    .push      (push),
    .push_data (push_data),
    .q_full    (q_full)
  );

  mwsp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  mwsp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_byte  (out_byte),
    .motor_id  (motor_id),
    .out_last  (m_tlast)
  );

  assign m_tdata = {5'd0, motor_id, out_byte};

endmodule

/* verif/mecanum_wheel_speed_packetizer_top_tb.sv */
module mecanum_wheel_speed_packetizer_top_tb;
  import mwsp_pkg::*;

  // Index with no register behind it; writes to it must be dropped
  localparam logic [2:0] REG_NONE = 3'd7;
  localparam int SETTLE_CYCLES = 12;
  localparam int MAX_REPORTS = 40;

  typedef struct {
    logic [7:0] data;
    logic [2:0] motor;
    logic       is_last;
  } frame_byte_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [47:0] s_tdata;   // vel_x[15:0], vel_y[31:16], yaw_rate[47:32]
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;   // out_byte[7:0], motor_id[10:8], zero[15:11]
  logic        m_tlast;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  cfg_t        regs_mirror;
  frame_byte_t pending_bytes[$];
  int          mismatches = 0;
  bit          no_idle = 1'b0;

  mecanum_wheel_speed_packetizer_top DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle) return 0;
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Expected 40 bytes for one command under the current register values
  function automatic void predict_motor_frames(input logic [15:0] vx_bits,
                                               input logic [15:0] vy_bits,
                                               input logic [15:0] yaw_bits);
    int          vx, vy, yaw, thr, lim, w, rpm;
    int          sums[MOTOR_COUNT];
    longint      prod;
    bit          braking;
    logic [15:0] urpm;
    logic [7:0]  frame[FRAME_LEN];
    logic [7:0]  crc;
    frame_byte_t fb;
    vx  = int'($signed(vx_bits));
    vy  = int'($signed(vy_bits));
    yaw = int'($signed(yaw_bits));
    thr = int'(regs_mirror.stop_threshold);
    braking = (vx < 0 ? -vx : vx) < thr && (vy < 0 ? -vy : vy) < thr &&
              (yaw < 0 ? -yaw : yaw) < thr;
    // yaw term rounds toward minus infinity
    prod = longint'(yaw) * longint'(regs_mirror.arm_gain);
    w = int'(prod >>> 16);
    lim = (regs_mirror.speed_cap > WHEEL_RPM_CEIL) ? int'(WHEEL_RPM_CEIL)
                                                   : int'(regs_mirror.speed_cap);
    sums[0] = vx + vy - w;
    sums[1] = vx - vy + w;
    sums[2] = vx - vy - w;
    sums[3] = vx + vy + w;
    for (int m = 0; m < MOTOR_COUNT; m++) begin
      rpm = 0;
      if (!braking) begin
        // signed division truncates toward zero
        prod = longint'(sums[m]) * longint'(regs_mirror.rpm_gain);
        prod = prod / 65536;
        if (prod > lim) prod = lim;
        if (prod < -lim) prod = -lim;
        rpm = int'(prod);
        if (regs_mirror.invert_mask[m]) rpm = -rpm;
      end
      urpm = 16'(rpm);
      frame[0] = 8'(m + 1);
      frame[1] = regs_mirror.mode_byte;
      frame[2] = urpm[15:8];
      frame[3] = urpm[7:0];
      frame[4] = 8'h00;
      frame[5] = 8'h00;
      frame[6] = regs_mirror.accel_byte;
      frame[7] = 8'h00;
      frame[8] = 8'h00;
      // reflected CRC-8 over the first nine bytes
      crc = 8'h00;
      for (int k = 0; k < FRAME_LEN - 1; k++) begin
        crc = crc ^ frame[k];
        for (int b = 0; b < 8; b++) begin
          crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
        end
      end
      frame[FRAME_LEN - 1] = crc;
      for (int k = 0; k < FRAME_LEN; k++) begin
        fb.data    = frame[k];
        fb.motor   = 3'(m + 1);
        fb.is_last = (m == MOTOR_COUNT - 1) && (k == FRAME_LEN - 1);
        pending_bytes.push_back(fb);
      end
    end
  endfunction

  // Sends one command, keeps tvalid up for back-to-back items
  task automatic send_command(input logic [15:0] vx, input logic [15:0] vy,
                              input logic [15:0] yaw);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tdata  <= {yaw, vy, vx};
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_motor_frames(vx, vy, yaw);
  endtask

  // Stop sending and let every expected byte come out
  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Leaves cfg_we high; caller lowers it after the last write
  task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    case (idx)
      REG_SPEED_CAP:      regs_mirror.speed_cap      = value[8:0];
      REG_STOP_THRESHOLD: regs_mirror.stop_threshold = value[9:0];
      REG_ARM_GAIN:       regs_mirror.arm_gain       = value;
      REG_RPM_GAIN:       regs_mirror.rpm_gain       = value;
      REG_INVERT_MASK:    regs_mirror.invert_mask    = value[3:0];
      REG_MODE_BYTE:      regs_mirror.mode_byte      = value[7:0];
      REG_ACCEL_BYTE:     regs_mirror.accel_byte     = value[7:0];
      default: ;
    endcase
  endtask

  task automatic apply_config(input cfg_t c);
    write_reg(REG_SPEED_CAP, 16'(c.speed_cap));
    write_reg(REG_NONE, 16'($urandom));
    write_reg(REG_STOP_THRESHOLD, 16'(c.stop_threshold));
    write_reg(REG_ARM_GAIN, c.arm_gain);
    write_reg(REG_RPM_GAIN, c.rpm_gain);
    write_reg(REG_INVERT_MASK, 16'(c.invert_mask));
    write_reg(REG_MODE_BYTE, 16'(c.mode_byte));
    write_reg(REG_ACCEL_BYTE, 16'(c.accel_byte));
    cfg_we <= 1'b0;
  endtask

  // Speed cap, threshold and both gains sit at an extreme now and then; all fields are random otherwise
  function automatic cfg_t random_config();
    cfg_t c;
    c.speed_cap      = ($urandom_range(0, 4) == 0) ? 9'($urandom_range(0, 1) * 511)
                                                   : 9'($urandom);
    c.stop_threshold = ($urandom_range(0, 4) == 0) ? 10'($urandom_range(0, 1) * 1023)
                                                   : 10'($urandom_range(0, 1200));
    c.arm_gain       = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(0, 1) * 65535)
                                                   : 16'($urandom);
    c.rpm_gain       = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(0, 1) * 65535)
                                                   : 16'($urandom);
    c.invert_mask    = 4'($urandom);
    c.mode_byte      = 8'($urandom);
    c.accel_byte     = 8'($urandom);
    return c;
  endfunction

  function automatic logic [15:0] pick_speed(input int thr);
    int sel, v;
    sel = $urandom_range(0, 9);
    case (sel)
      0: begin
        case ($urandom_range(0, 3))
          0: v = -32768;
          1: v = 32767;
          2: v = 0;
          default: v = -1;
        endcase
      end
      1, 2: begin
        // right around the brake threshold
        v = thr + int'($urandom_range(0, 3)) - 2;
        if (v < 0) v = 0;
        if ($urandom_range(0, 1)) v = -v;
      end
      3, 4, 5, 6: v = int'($urandom_range(0, 4000)) - 2000;
      default: v = int'($urandom_range(0, 65535));
    endcase
    return 16'(v);
  endfunction

  // Reset values, brake boundary and full-scale commands
  task automatic test_default_regs();
    send_command(16'd0, 16'd0, 16'd0);
    send_command(16'd100, 16'd0, 16'd0);
    send_command(-16'sd100, 16'd0, 16'd0);
    send_command(16'd0, -16'sd250, 16'd0);
    send_command(16'd0, 16'd0, 16'd300);
    send_command(16'd19, -16'sd19, 16'd19);
    send_command(16'd20, 16'd0, 16'd0);
    send_command(16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_command(16'h8000, 16'h8000, 16'h8000);
    drain();
  endtask

  // Register extremes: limit above motor maximum and zero, full and zero gains, widest and zero threshold
  task automatic test_extreme_regs();
    cfg_t c;
    c = '{speed_cap: 9'd511, stop_threshold: 10'd0, arm_gain: 16'hFFFF,
          rpm_gain: 16'hFFFF, invert_mask: 4'hF, mode_byte: 8'hFF, accel_byte: 8'hFF};
    apply_config(c);
    send_command(16'd0, 16'd0, 16'd0);
    send_command(16'd0, 16'd0, -16'sd3);
    send_command(16'd200, -16'sd100, 16'd50);
    send_command(16'h7FFF, 16'h8000, 16'h7FFF);
    send_command(16'h8000, 16'h7FFF, 16'h8000);
    send_command(16'hFFFF, 16'hFFFF, 16'hFFFF);
    drain();
    c = '{speed_cap: 9'd330, stop_threshold: 10'd1023, arm_gain: 16'h0000,
          rpm_gain: 16'hFFFF, invert_mask: 4'h0, mode_byte: 8'h00, accel_byte: 8'h00};
    apply_config(c);
    send_command(16'd1022, -16'sd1022, 16'd1022);
    send_command(16'd1023, 16'd0, 16'd0);
    send_command(16'd0, 16'd0, -16'sd1023);
    drain();
    c = '{speed_cap: 9'd0, stop_threshold: 10'd0, arm_gain: 16'd1,
          rpm_gain: 16'd1, invert_mask: 4'hA, mode_byte: 8'h5A, accel_byte: 8'hA5};
    apply_config(c);
    send_command(16'h7FFF, 16'h7FFF, 16'h8000);
    drain();
  endtask

  // Random commands under a series of random register settings
  task automatic test_random_commands();
    int thr;
    logic [15:0] vx, vy, yaw;
    for (int phase = 0; phase < 7; phase++) begin
      apply_config(random_config());
      no_idle = (phase == 3);
      thr = int'(regs_mirror.stop_threshold);
      for (int n = 0; n < 66; n++) begin
        if ($urandom_range(0, 6) == 0) begin
          // all three small: brakes unless one reaches the threshold
          vx  = 16'(($urandom_range(0, 1) ? -1 : 1) * int'($urandom_range(0, thr)));
          vy  = 16'(($urandom_range(0, 1) ? -1 : 1) * int'($urandom_range(0, thr)));
          yaw = 16'(($urandom_range(0, 1) ? -1 : 1) * int'($urandom_range(0, thr)));
        end else begin
          vx  = pick_speed(thr);
          vy  = pick_speed(thr);
          yaw = pick_speed(thr);
        end
        send_command(vx, vy, yaw);
      end
      drain();
      no_idle = 1'b0;
    end
  endtask

  // Receiver: bursts of ready with random stalls
  initial begin
    int burst, gap;
    forever begin
      m_tready <= 1'b1;
      burst = $urandom_range(1, 30);
      repeat (burst) @(posedge clk);
      gap = pick_gap();
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  // Compare each output byte with the oldest expectation
  always @(posedge clk) begin
    frame_byte_t fb;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_bytes.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected byte %h id %0d last %b", $time,
                   m_tdata[7:0], m_tdata[10:8], m_tlast);
      end else begin
        fb = pending_bytes.pop_front();
        if (m_tdata[7:0] !== fb.data || m_tdata[10:8] !== fb.motor ||
            m_tlast !== fb.is_last) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: expected byte %h id %0d last %b, got byte %h id %0d last %b",
                     $time, fb.data, fb.motor, fb.is_last,
                     m_tdata[7:0], m_tdata[10:8], m_tlast);
        end
      end
    end
  end

  initial begin
    #40_000_000;
    $display("[mecanum_wheel_speed_packetizer_top] ERROR");
    $finish;
  end

  initial begin
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= REG_SPEED_CAP;
    cfg_data  <= '0;
    regs_mirror = '{speed_cap: RST_SPEED_CAP, stop_threshold: RST_STOP_THRESHOLD,
                    arm_gain: RST_ARM_GAIN, rpm_gain: RST_RPM_GAIN,
                    invert_mask: RST_INVERT_MASK, mode_byte: RST_MODE_BYTE,
                    accel_byte: RST_ACCEL_BYTE};
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_default_regs();
    test_extreme_regs();
    test_random_commands();
    drain();
    if (mismatches == 0 && pending_bytes.size() == 0) begin
      $display("[mecanum_wheel_speed_packetizer_top] OK");
    end else begin
      $display("[mecanum_wheel_speed_packetizer_top] ERROR");
    end
    $finish;
  end

endmodule
